[rtl/core/i2cm_pkg.sv]
// Shared types, opcodes and phase tables for the I2C master byte engine.
`default_nettype none
package i2cm_pkg;

    localparam int unsigned HalfPeriodW     = 16;
    localparam logic [15:0] HalfPeriodReset = 16'd50;
    localparam int unsigned PhaseW          = 5;
    localparam int unsigned InDataW         = 16;
    localparam int unsigned OutDataW        = 16;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_CHECK = 3'd3,
        OP_READ  = 3'd4,
        OP_IDLE  = 3'd7
    } t_op;

    // line levels: bit 1 is SCL, bit 0 pulls SDA low
    localparam logic [1:0] LvScl  = 2'b10;
    localparam logic [1:0] LvPull = 2'b01;

    typedef struct packed {
        logic       sda_in;
        logic       send_ack;
        logic [7:0] write_data;
        logic [2:0] opcode;
        logic       cmd_valid;
    } t_item;

    typedef struct packed {
        logic       ack_received;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } t_result;

    function automatic logic [PhaseW-1:0] phase_total(input t_op op);
        logic [PhaseW-1:0] n;
        case (op)
            OP_START: n = 5'd3;
            OP_STOP:  n = 5'd2;
            OP_WRITE: n = 5'd16;
            OP_CHECK: n = 5'd3;
            OP_READ:  n = 5'd19;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

[rtl/core/i2cm_in_reg.sv]
// Input word register in front of the line sequencer.
`default_nettype none
module i2cm_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire i2cm_pkg::t_item i_item,
    input  wire logic            i_advance,
    output logic                 o_valid,
    output i2cm_pkg::t_item      o_item
);
    import i2cm_pkg::*;

    logic  r_valid;
    t_item r_item;

    // refill when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

[rtl/core/i2cm_seq.sv]
// Bus phase sequencer: command state, tick counter, shift byte and line levels.
`default_nettype none
module i2cm_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [i2cm_pkg::HalfPeriodW-1:0] i_cfg_data,
    input  wire logic                           i_step,
    input  wire i2cm_pkg::t_item                i_item,
    output i2cm_pkg::t_result                   o_result
);
    import i2cm_pkg::*;

    logic [HalfPeriodW-1:0] r_half_period;
    t_op                    r_op,     n_op;
    logic [PhaseW-1:0]      r_phase,  n_phase;
    logic [HalfPeriodW-1:0] r_tick,   n_tick;
    logic [7:0]             r_shift,  n_shift;
    logic                   r_ack_choice, n_ack_choice;
    logic                   r_ack_flag,   n_ack_flag;
    logic [1:0]             r_lines,  n_lines;
    logic [7:0]             r_latch,  n_latch;
    logic                   done;

    logic [HalfPeriodW-1:0] hp;
    logic [HalfPeriodW-1:0] tick_inc;
    logic [PhaseW-1:0]      phase_inc;

    function automatic logic [1:0] levels_of(input t_op op, input logic [PhaseW-1:0] ph,
                                             input logic [7:0] byte_val, input logic ack,
                                             input logic [1:0] cur);
        logic [1:0] lv;
        logic [2:0] bit_idx;
        bit_idx = ph[3:1];
        case (op)
            OP_START: begin
                if (ph == 5'd0)      lv = LvScl;
                else if (ph == 5'd1) lv = LvScl | LvPull;
                else                 lv = LvPull;
            end
            OP_STOP:  lv = (ph == 5'd0) ? LvPull : (LvScl | LvPull);
            OP_WRITE: lv = {~ph[0], ~byte_val[3'd7 - bit_idx]};
            OP_CHECK: lv = (ph < 5'd2) ? LvScl : 2'b00;
            OP_READ: begin
                if (ph < 5'd16) lv = {ph[0], 1'b0};
                else            lv = {ph == 5'd17, ack};
            end
            default:  lv = cur;
        endcase
        return lv;
    endfunction

    assign hp        = (r_half_period == '0) ? HalfPeriodW'(1) : r_half_period;
    assign tick_inc  = r_tick + HalfPeriodW'(1);
    assign phase_inc = r_phase + PhaseW'(1);

    // next state
    always_comb begin
        n_op         = r_op;
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_ack_flag   = r_ack_flag;
        n_lines      = r_lines;
        n_latch      = r_latch;
        done         = 1'b0;
        if (r_op == OP_IDLE) begin
            if (i_item.cmd_valid && (i_item.opcode inside {[3'd0:3'd4]})) begin
                n_op    = t_op'(i_item.opcode);
                n_phase = '0;
                n_tick  = '0;
                if (n_op == OP_WRITE) n_shift = i_item.write_data;
                if (n_op == OP_READ) begin
                    n_shift      = 8'h00;
                    n_ack_choice = i_item.send_ack;
                end
                n_lines = levels_of(n_op, '0, n_shift, n_ack_choice, r_lines);
            end
        end else begin
            n_tick = tick_inc;
            if (tick_inc >= hp) begin
                n_tick = '0;
                if (r_op == OP_CHECK && r_phase == '0) n_ack_flag = ~i_item.sda_in;
                // sample on the last tick of each SCL-high data phase
                if (r_op == OP_READ && r_phase < 5'd16 && r_phase[0]) begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                end
                if (phase_inc >= phase_total(r_op)) begin
                    done    = 1'b1;
                    if (r_op == OP_STOP) n_lines = LvScl;
                    if (r_op == OP_READ) n_latch = n_shift;
                    n_op    = OP_IDLE;
                    n_phase = '0;
                end else begin
                    n_phase = phase_inc;
                    n_lines = levels_of(r_op, phase_inc, r_shift, r_ack_choice, r_lines);
                end
            end
        end
    end

    // result word
    always_comb begin
        o_result.scl_level    = n_lines[1];
        o_result.sda_pull_low = n_lines[0];
        o_result.busy_res     = (n_op != OP_IDLE);
        o_result.done_res     = done;
        o_result.read_data    = n_latch;
        o_result.ack_received = n_ack_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HalfPeriodReset;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op         <= OP_IDLE;
            r_phase      <= '0;
            r_tick       <= '0;
            r_shift      <= 8'h00;
            r_ack_choice <= 1'b0;
            r_ack_flag   <= 1'b0;
            r_lines      <= LvScl;
            r_latch      <= 8'h00;
        end else if (i_step) begin
            r_op         <= n_op;
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_ack_flag   <= n_ack_flag;
            r_lines      <= n_lines;
            r_latch      <= n_latch;
        end
    end

endmodule
`default_nettype wire

[rtl/core/i2c_master_byte_engine_unit.sv]
// Top level of the I2C master byte engine: input register, sequencer, result register.
`default_nettype none
// I2C master line sequencer stepped by timebase ticks. Each word on the slave
// stream is one tick carrying an optional command and the sampled SDA level;
// each tick gives exactly one result word with the SCL level, the SDA pull-down,
// busy, done, the last read byte and the last acknowledge. A command is taken
// only while idle and runs for its phase count times half_period ticks (a zero
// half_period counts as one). Words are accepted at one per clock while the master
// side is ready: a tick sits in the input register while the sequencer works out
// its result combinationally, and the result register captures it when the master
// side is ready. A stalled master side holds both registers and drops s_tready.
// The user must write half_period on the cfg channel only while no command is
// running; the block itself does not enforce it.
module i2c_master_byte_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [0] cmd_valid, [3:1] opcode, [11:4] write_data, [12] send_ack, [13] sda_in
    input  wire logic [i2cm_pkg::InDataW-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_received
    output logic [i2cm_pkg::OutDataW-1:0]      o_m_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [i2cm_pkg::HalfPeriodW-1:0] i_cfg_data
);
    import i2cm_pkg::*;

    t_item   s_item;
    t_item   q_item;
    logic    q_valid;
    logic    advance;
    t_result result;
    logic    r_out_valid;
    t_result r_out;

    assign s_item      = t_item'(i_s_tdata[$bits(t_item)-1:0]);
    assign advance     = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    i2cm_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (s_item),
        .i_advance (advance),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    i2cm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_step     (q_valid && advance),
        .i_item     (q_item),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && q_valid) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OutDataW - $bits(t_result))'(0), r_out};

endmodule
`default_nettype wire

[tb/i2cm_line_checker.sv]
// Checker for the I2C master byte engine: tracks the bus sequencer and compares result words.
module i2cm_line_checker
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fails,
    output int          o_pending,
    output logic        o_busy,
    output int          o_checked
);

    int          fails   = 0;
    int          checked = 0;
    t_result     expected_lines[$];

    // own copy of the sequencer
    logic [15:0] half_period = HalfPeriodReset;
    t_op         act_op      = OP_IDLE;
    logic [4:0]  phase       = '0;
    logic [15:0] tick_cnt    = '0;
    logic [7:0]  shift_reg   = '0;
    logic        ack_sel     = 1'b0;
    logic        ack_seen    = 1'b0;
    logic [1:0]  lines       = LvScl;
    logic [7:0]  read_latch  = '0;

    initial begin
        o_fails   = 0;
        o_pending = 0;
        o_busy    = 1'b0;
        o_checked = 0;
    end

    function automatic logic [4:0] phases_in(input t_op op);
        case (op)
            OP_START: return 5'd3;
            OP_STOP:  return 5'd2;
            OP_WRITE: return 5'd16;
            OP_CHECK: return 5'd3;
            OP_READ:  return 5'd19;
            default:  return 5'd0;
        endcase
    endfunction

    function automatic logic [1:0] bus_levels(input t_op op, input logic [4:0] p,
                                              input logic [7:0] sb, input logic ac,
                                              input logic [1:0] cur);
        logic [1:0] lv;
        case (op)
            OP_START: lv = (p == 0) ? LvScl : (p == 1) ? (LvScl | LvPull) : LvPull;
            OP_STOP:  lv = (p == 0) ? LvPull : (LvScl | LvPull);
            OP_WRITE: begin
                // data bit held low or released, SCL high on even phases
                lv = sb[3'd7 - p[3:1]] ? 2'b00 : LvPull;
                if (!p[0]) lv = lv | LvScl;
            end
            OP_CHECK: lv = (p < 2) ? LvScl : 2'b00;
            OP_READ: begin
                if (p < 16) lv = p[0] ? LvScl : 2'b00;
                else lv = ((p == 17) ? LvScl : 2'b00) | (ac ? LvPull : 2'b00);
            end
            default:  lv = cur;
        endcase
        return lv;
    endfunction

    task automatic advance_bus(input t_item it);
        logic [15:0] span;
        logic        done;
        t_result     r;
        span = (half_period == 0) ? 16'd1 : half_period;
        done = 1'b0;
        if (act_op == OP_IDLE) begin
            if (it.cmd_valid && it.opcode <= OP_READ) begin
                act_op   = t_op'(it.opcode);
                phase    = '0;
                tick_cnt = '0;
                if (act_op == OP_WRITE) shift_reg = it.write_data;
                if (act_op == OP_READ) begin
                    shift_reg = '0;
                    ack_sel   = it.send_ack;
                end
                lines = bus_levels(act_op, phase, shift_reg, ack_sel, lines);
            end
        end else begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= span) begin
                tick_cnt = '0;
                if (act_op == OP_CHECK && phase == 0) ack_seen = !it.sda_in;
                if (act_op == OP_READ && phase < 16 && phase[0])
                    shift_reg = {shift_reg[6:0], it.sda_in};
                phase = phase + 5'd1;
                if (phase >= phases_in(act_op)) begin
                    done = 1'b1;
                    // stop leaves the bus released
                    if (act_op == OP_STOP) lines = LvScl;
                    if (act_op == OP_READ) read_latch = shift_reg;
                    act_op = OP_IDLE;
                    phase  = '0;
                end else begin
                    lines = bus_levels(act_op, phase, shift_reg, ack_sel, lines);
                end
            end
        end
        r.scl_level    = lines[1];
        r.sda_pull_low = lines[0];
        r.busy_res     = (act_op != OP_IDLE);
        r.done_res     = done;
        r.read_data    = read_latch;
        r.ack_received = ack_seen;
        expected_lines.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            if (fails < 10)
                $display("ERROR %0t: result %0d field %s expected %0h actual %0h",
                         $time, checked, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            half_period = HalfPeriodReset;
            act_op      = OP_IDLE;
            phase       = '0;
            tick_cnt    = '0;
            shift_reg   = '0;
            ack_sel     = 1'b0;
            ack_seen    = 1'b0;
            lines       = LvScl;
            read_latch  = '0;
            expected_lines.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) half_period = i_cfg_data;
            if (i_s_tvalid && i_s_tready) advance_bus(t_item'(i_s_tdata[13:0]));
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[12:0]);
                if (expected_lines.size() == 0) begin
                    if (fails < 10)
                        $display("ERROR %0t: result word %h with nothing expected",
                                 $time, i_m_tdata);
                    fails++;
                end else begin
                    want = expected_lines.pop_front();
                    compare_field("scl_level", want.scl_level, got.scl_level);
                    compare_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
                    compare_field("busy_res", want.busy_res, got.busy_res);
                    compare_field("done_res", want.done_res, got.done_res);
                    compare_field("read_data", want.read_data, got.read_data);
                    compare_field("ack_received", want.ack_received, got.ack_received);
                    compare_field("padding", 8'd0, {5'd0, i_m_tdata[15:13]});
                    checked++;
                end
            end
        end
        o_fails   <= fails;
        o_pending <= expected_lines.size();
        o_busy    <= (act_op != OP_IDLE);
        o_checked <= checked;
    end

endmodule

[tb/i2c_master_byte_engine_unit_test.sv]
// Testbench top for the I2C master byte engine: clock, reset, tick stimulus and verdict.
module i2c_master_byte_engine_unit_test;
    import i2cm_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [15:0] s_tdata     = '0;
    logic        m_tready    = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [15:0] cfg_data    = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        cfg_ready;

    int          fails;
    int          pending;
    logic        seq_busy;
    int          checked;

    logic [15:0] hp_now       = HalfPeriodReset;
    int          burst_left   = 0;
    bit          gaps_on      = 1'b1;
    int          ticks_sent   = 0;
    int          cmds_offered = 0;
    logic [15:0] rx_cnt       = '0;
    logic [1:0]  rx_mode      = '0;

    always #5 i_clk = ~i_clk;

    i2c_master_byte_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    i2cm_line_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fails     (fails),
        .o_pending   (pending),
        .o_busy      (seq_busy),
        .o_checked   (checked)
    );

    // receiver: pick a new random stall pattern whenever the low byte of rx_cnt is FF
    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 16'd1;
        if (rx_cnt[7:0] == 8'hFF) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= (rx_cnt[1:0] != 2'b11);
            2'd2:    m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= rx_cnt[2];
        endcase
    end

    function automatic logic [15:0] tick_word(input logic cv, input logic [2:0] opc,
                                              input logic [7:0] wd, input logic sa,
                                              input logic sda);
        t_item it;
        it.cmd_valid  = cv;
        it.opcode     = opc;
        it.write_data = wd;
        it.send_ack   = sa;
        it.sda_in     = sda;
        return {2'b00, it};
    endfunction

    // ticks the sequencer stays busy after taking a command
    function automatic int busy_ticks(input logic [2:0] opc);
        int n;
        case (opc)
            OP_START: n = 3;
            OP_STOP:  n = 2;
            OP_WRITE: n = 16;
            OP_CHECK: n = 3;
            OP_READ:  n = 19;
            default:  n = 0;
        endcase
        return n * ((hp_now == 0) ? 1 : int'(hp_now));
    endfunction

    function automatic logic sda_for(input int mode);
        if (mode == 0) return 1'b0;
        if (mode == 1) return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic push_tick(input logic [15:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        ticks_sent++;
    endtask

    // offer a command, then tick through its busy time with optional noise
    task automatic run_cmd(input logic [2:0] opc, input logic [7:0] wd, input logic sa,
                           input int sda_mode, input int noise_pct, input bit hit_end);
        int n;
        logic cv;
        logic [2:0] nop;
        push_tick(tick_word(1'b1, opc, wd, sa, sda_for(sda_mode)));
        cmds_offered++;
        n = busy_ticks(opc);
        for (int i = 1; i <= n; i++) begin
            cv  = ($urandom_range(0, 99) < noise_pct);
            nop = 3'($urandom_range(0, 7));
            if (hit_end && i == n) begin
                cv  = 1'b1;
                nop = OP_START;
            end
            push_tick(tick_word(cv, nop, 8'($urandom), 1'($urandom_range(0, 1)),
                                sda_for(sda_mode)));
        end
        repeat ($urandom_range(0, 2))
            push_tick(tick_word(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                                1'($urandom_range(0, 1)), sda_for(2)));
    endtask

    task automatic wait_drain;
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // hold off until the sequencer is idle and every result word is back
    task automatic set_half_period(input logic [15:0] v);
        wait_drain();
        while (seq_busy) begin
            push_tick(tick_word(1'b0, OP_IDLE, 8'h00, 1'b0, 1'b1));
            wait_drain();
        end
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hp_now = v;
    endtask

    initial begin
        #50_000_000;
        $display("i2c_master_byte_engine_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] hp_list [5];
        logic [2:0]  cmd_op;
        int tick_start;
        int waited;
        int leftover;
        hp_list = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd5};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset half period
        run_cmd(OP_START, 8'h00, 1'b0, 2, 0, 1'b0);

        set_half_period(16'd1);
        run_cmd(OP_START, 8'h00, 1'b0, 1, 0, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b0, 2, 0, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, 2, 0, 1'b0);
        run_cmd(OP_WRITE, 8'hA5, 1'b1, 2, 50, 1'b0);
        run_cmd(OP_CHECK, 8'h00, 1'b0, 0, 0, 1'b0);
        run_cmd(OP_CHECK, 8'h00, 1'b0, 1, 0, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b1, 1, 0, 1'b0);
        run_cmd(OP_READ, 8'hFF, 1'b0, 0, 0, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b1, 2, 100, 1'b1);
        run_cmd(3'd5, 8'hFF, 1'b1, 2, 0, 1'b0);
        run_cmd(3'd6, 8'h00, 1'b0, 2, 0, 1'b0);
        run_cmd(3'd7, 8'hFF, 1'b1, 2, 0, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 2, 100, 1'b1);
        run_cmd(OP_CHECK, 8'h00, 1'b0, 2, 0, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1, 0, 1'b0);

        // random commands and noise on a tick budget per half period
        foreach (hp_list[p]) begin
            set_half_period(hp_list[p]);
            tick_start = ticks_sent;
            while (ticks_sent - tick_start < 80) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 6))
                        push_tick(tick_word(1'($urandom_range(0, 1)),
                                            3'($urandom_range(0, 7)), 8'($urandom),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))));
                end else begin
                    cmd_op = 3'($urandom_range(0, 4));
                    run_cmd(cmd_op, 8'($urandom), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 2), 15, ($urandom_range(0, 19) == 0));
                end
            end
        end

        // widest half period: take a stop and tick part way into its first phase
        gaps_on = 1'b0;
        set_half_period(16'hFFFF);
        push_tick(tick_word(1'b1, OP_STOP, 8'h00, 1'b0, 1'b1));
        cmds_offered++;
        repeat (24)
            push_tick(tick_word(1'b0, OP_IDLE, 8'h00, 1'b0, sda_for(2)));

        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < 2000);
        repeat (10) @(posedge i_clk);

        leftover = pending;
        if (leftover != 0) $display("ERROR: %0d expected result words never arrived", leftover);
        $display("Covered %0d ticks and %0d commands at half periods 50, 1, 0, 2, 3, 5, 65535",
                 ticks_sent, cmds_offered);
        $display("Compared %0d result words, %0d field errors", checked, fails);
        if (fails == 0 && leftover == 0) begin
            $display("i2c_master_byte_engine_unit: match");
        end else begin
            $display("i2c_master_byte_engine_unit: mismatch");
        end
        $finish;
    end

endmodule
